// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; every use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition c must hold in the same cycle as a
`define STWQ_ASSERT_IMPLIES(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// condition c must hold in the cycle after a
`define STWQ_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

// ----- hdl/stwq_pkg.sv -----
// ----------------------------------------------------------------------------
// stwq_pkg
// Shared types and codes of the semaphore table with wait queues.
// ----------------------------------------------------------------------------
package stwq_pkg;

  // default sizes
  localparam int SEM_SLOTS_DEF  = 16;
  localparam int WAIT_DEPTH_DEF = 8;

  // operation codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_WAIT   = 2'd2;
  localparam logic [1:0] OP_SIGNAL = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;

  // count limits
  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
  localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;

  // one registered request
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         idx;
    logic [7:0]         pid;
    logic signed [15:0] init;
  } req_t;

  // result flags of one request (woken pid comes from the queue memory)
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] new_slot;
    logic       blocked;
    logic       overflow;
    logic       woken;
  } res_t;

endpackage

// ----- hdl/stwq_ram.sv -----
// ----------------------------------------------------------------------------
// stwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/stwq_slots.sv -----
// ----------------------------------------------------------------------------
// stwq_slots
// Per-slot semaphore state, free-slot search and the single-pass decision
// for create, close, wait and signal; drives the wait queue memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stwq_slots #(
  parameter int SEM_SLOTS  = 16,
  parameter int WAIT_DEPTH = 8,
  parameter int SLOT_W     = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1,
  parameter int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
  parameter int QA_W       = SLOT_W + PTR_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  stwq_pkg::req_t    req,
  output stwq_pkg::res_t    res,
  output logic              q_we,
  output logic [QA_W-1:0]   q_waddr,
  output logic [7:0]        q_wdata,
  output logic              q_re,
  output logic [QA_W-1:0]   q_raddr
);
  import stwq_pkg::*;

  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  // slot state
  logic [SEM_SLOTS-1:0]     used_r;
  logic [7:0]               creator_r [SEM_SLOTS];
  logic signed [15:0]       count_r   [SEM_SLOTS];
  logic [PTR_W-1:0]         head_r    [SEM_SLOTS];
  logic [PTR_W-1:0]         tail_r    [SEM_SLOTS];
  logic [CNT_W-1:0]         wcnt_r    [SEM_SLOTS];

  logic                     in_range;
  logic [SLOT_W-1:0]        sel;
  logic                     cur_used;
  logic [7:0]               cur_creator;
  logic signed [15:0]       cur_count;
  logic [PTR_W-1:0]         cur_head;
  logic [PTR_W-1:0]         cur_tail;
  logic [CNT_W-1:0]         cur_wcnt;
  logic signed [15:0]       cnt_dec;
  logic signed [15:0]       cnt_inc;
  logic [PTR_W-1:0]         head_nxt;
  logic [PTR_W-1:0]         tail_nxt;
  logic                     free_found;
  logic [SLOT_W-1:0]        free_idx;
  logic                     do_create;
  logic                     do_close;
  logic                     do_wait;
  logic                     do_signal;
  logic                     enq;
  logic                     deq;

  // addressed slot
  assign in_range    = ({1'b0, req.idx} < 9'(SEM_SLOTS));
  assign sel         = in_range ? req.idx[SLOT_W-1:0] : '0;
  assign cur_used    = used_r[sel];
  assign cur_creator = creator_r[sel];
  assign cur_count   = count_r[sel];
  assign cur_head    = head_r[sel];
  assign cur_tail    = tail_r[sel];
  assign cur_wcnt    = wcnt_r[sel];

  // saturating count update
  assign cnt_dec = (cur_count > COUNT_MIN) ? cur_count - 16'sd1 : cur_count;
  assign cnt_inc = (cur_count < COUNT_MAX) ? cur_count + 16'sd1 : cur_count;

  // ring pointer advance
  assign head_nxt = (cur_head == PTR_W'(WAIT_DEPTH - 1)) ? '0 : cur_head + PTR_W'(1);
  assign tail_nxt = (cur_tail == PTR_W'(WAIT_DEPTH - 1)) ? '0 : cur_tail + PTR_W'(1);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // operation decode and result flags
  always_comb begin
    res       = '0;
    do_create = 1'b0;
    do_close  = 1'b0;
    do_wait   = 1'b0;
    do_signal = 1'b0;
    enq       = 1'b0;
    deq       = 1'b0;
    if (req_valid) begin
      if (req.op == OP_CREATE) begin
        if (free_found) begin
          do_create    = 1'b1;
          res.new_slot = 4'(free_idx);
        end else begin
          res.status = ST_NOFREE;
        end
      end else if (!(in_range && cur_used)) begin
        res.status = ST_IGNORED;
      end else begin
        unique case (req.op)
          OP_CLOSE: begin
            if (cur_creator == req.pid) begin
              do_close = 1'b1;
            end else begin
              res.status = ST_IGNORED;
            end
          end
          OP_WAIT: begin
            do_wait = 1'b1;
            if (cnt_dec < 16'sd0) begin
              if (cur_wcnt < CNT_W'(WAIT_DEPTH)) begin
                enq         = 1'b1;
                res.blocked = 1'b1;
              end else begin
                res.overflow = 1'b1;
              end
            end
          end
          OP_SIGNAL: begin
            do_signal = 1'b1;
            if (cur_wcnt != '0) begin
              deq       = 1'b1;
              res.woken = 1'b1;
            end
          end
          default: begin
            res.status = ST_IGNORED;
          end
        endcase
      end
    end
  end

  // wait queue memory access
  assign q_we    = enq;
  assign q_waddr = {sel, cur_tail};
  assign q_wdata = req.pid;
  assign q_re    = deq;
  assign q_raddr = {sel, cur_head};

  // slot state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < SEM_SLOTS; i++) begin
        creator_r[i] <= '0;
        count_r[i]   <= '0;
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        wcnt_r[i]    <= '0;
      end
    end else if (do_create) begin
      used_r[free_idx]    <= 1'b1;
      creator_r[free_idx] <= req.pid;
      count_r[free_idx]   <= req.init;
      head_r[free_idx]    <= '0;
      tail_r[free_idx]    <= '0;
      wcnt_r[free_idx]    <= '0;
    end else if (do_close) begin
      used_r[sel] <= 1'b0;
    end else if (do_wait) begin
      count_r[sel] <= cnt_dec;
      if (enq) begin
        tail_r[sel] <= tail_nxt;
        wcnt_r[sel] <= cur_wcnt + CNT_W'(1);
      end
    end else if (do_signal) begin
      count_r[sel] <= cnt_inc;
      if (deq) begin
        head_r[sel] <= head_nxt;
        wcnt_r[sel] <= cur_wcnt - CNT_W'(1);
      end
    end
  end

  // checks
  `STWQ_ASSERT_IMPLIES(a_one_queue_op, q_we, !q_re, "enqueue and dequeue in one cycle")
  `STWQ_ASSERT_IMPLIES(a_wcnt_bound, req_valid && in_range,
                       cur_wcnt <= CNT_W'(WAIT_DEPTH), "waiter count above queue depth")
  `STWQ_ASSERT_NEXT(a_create_marks, do_create, used_r[$past(free_idx)],
                    "created slot not marked used")

endmodule

// ----- hdl/semaphore_table_with_wait_queues.sv -----
// Each request passes the input register, the combinational decision and the result register.
// Throughput: one operation per cycle; busy stays low outside reset.
// Each operation makes one combinational pass through the slot table; the woken pid
// comes from the registered read port of the wait queue memory.
// Reset: synchronous, active low; all slots free, busy registered high and low once released.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// semaphore_table_with_wait_queues
// Table of counting semaphores, each with a FIFO queue of blocked ids.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module semaphore_table_with_wait_queues #(
  parameter int SEM_SLOTS  = stwq_pkg::SEM_SLOTS_DEF,
  parameter int WAIT_DEPTH = stwq_pkg::WAIT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_sem_index,
  input  logic [7:0]         in_caller_pid,
  input  logic signed [15:0] in_initial_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_new_slot,
  output logic               out_caller_blocked,
  output logic               out_queue_overflow,
  output logic               out_woken_valid,
  output logic [7:0]         out_woken_pid
);
  import stwq_pkg::*;

  localparam int SLOT_W = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int QA_W   = SLOT_W + PTR_W;
  localparam int QDEPTH = SEM_SLOTS * (2 ** PTR_W);

  logic            busy_r;
  logic            in_valid_r;
  req_t            req_r;
  res_t            res_nxt;
  res_t            res_r;
  logic            out_valid_r;
  logic            q_we;
  logic [QA_W-1:0] q_waddr;
  logic [7:0]      q_wdata;
  logic            q_re;
  logic [QA_W-1:0] q_raddr;
  logic [7:0]      q_rdata;

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      req_r.op   <= in_operation;
      req_r.idx  <= in_sem_index;
      req_r.pid  <= in_caller_pid;
      req_r.init <= in_initial_value;
    end
  end

  // slot table and decision
  stwq_slots #(
    .SEM_SLOTS  (SEM_SLOTS),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid_r),
    .req       (req_r),
    .res       (res_nxt),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_re      (q_re),
    .q_raddr   (q_raddr)
  );

  // wait queue store, one ring of entries per slot
  stwq_ram #(
    .WIDTH (8),
    .DEPTH (QDEPTH),
    .AW    (QA_W)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // result ports
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_new_slot       = res_r.new_slot;
  assign out_caller_blocked = res_r.blocked;
  assign out_queue_overflow = res_r.overflow;
  assign out_woken_valid    = res_r.woken;
  assign out_woken_pid      = res_r.woken ? q_rdata : 8'd0;

  // checks
  `STWQ_ASSERT_IMPLIES(a_out_timing, out_valid, $past(start && !busy, 2),
                       "result without an accepted item two cycles earlier")
  `STWQ_ASSERT_IMPLIES(a_woken_done, out_valid && out_woken_valid,
                       out_status == ST_DONE && !out_caller_blocked && !out_queue_overflow,
                       "woken result with conflicting flags")
  `STWQ_ASSERT_IMPLIES(a_fail_clear, out_valid && out_status != ST_DONE,
                       !out_woken_valid && !out_caller_blocked && !out_queue_overflow &&
                       out_new_slot == 4'd0, "failed operation with flags set")

endmodule
